>>> hdl/chm_pkg.sv
// Package for the chained hash map: transaction payload types, operation codes,
// default sizes and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;

  localparam int BUCKETS_DEF  = 509;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] old_value;
    logic [10:0] entry_total;
    logic        pool_full;
  } out_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic hash_cap;
    logic cur_from_head;
    logic hit;
    logic advance;
    logic wr_val_cur;
    logic rd_free;
    logic alloc_fresh;
    logic alloc_free;
    logic set_full;
    logic rm_link;
    logic unlink;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       cur_nil;
    logic       key_match;
    logic       free_nil;
    logic       fresh_avail;
    logic       clr_last;
    logic [1:0] mode;
  } stat_t;

endpackage
`default_nettype wire

>>> hdl/chm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hdl/chm_dp.sv
// Datapath of the chained hash map: bucket hash, chain walk registers, pool
// bookkeeping and the four storage RAMs. Depends on chm_pkg and chm_ram.
`timescale 1ns / 1ps
`default_nettype none
module chm_dp #(
  parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
  parameter int CAPACITY = chm_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire chm_pkg::cmd_t  cmd,
  output chm_pkg::stat_t      stat,
  input  wire chm_pkg::in_t   in_data,
  output chm_pkg::out_t       out_data
);
  import chm_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW = $clog2(BUCKETS);
  localparam int SH = 30 + BW;
  localparam logic [63:0] RECIP = (64'd1 << SH) / BUCKETS;
  localparam logic [SW-1:0] NIL = SW'(CAPACITY);

  in_t            item_r;
  logic [29:0]    q_r;
  logic [BW:0]    rem_r;
  logic [BW-1:0]  b_r;
  logic [SW-1:0]  cur_r, prev_r, headv_r, nxt_r;
  logic           found_r, full_r;
  logic [31:0]    oldv_r;
  logic [SW-1:0]  free_head_r, fresh_r, live_r;
  logic [BW-1:0]  clr_cnt_r;
  out_t           out_r;

  logic [29:0]    x;
  logic [61:0]    p1;
  logic [29:0]    p2;
  logic [BW:0]    rem_fix;

  logic           head_we;
  logic [BW-1:0]  head_wa;
  logic [SW-1:0]  head_wd, head_rd;
  logic           link_we, kv_we, val_we;
  logic [SW-1:0]  link_wa_s, link_wd, link_rd, val_wa_s, slot;
  logic [31:0]    key_rd, val_rd;
  logic [IW-1:0]  ent_ra;

  // Bucket = (key >> 2) mod BUCKETS by reciprocal multiply and one correction.
  assign x       = item_r.key[31:2];
  assign p1      = 62'(x) * 62'(RECIP[31:0]);
  assign p2      = q_r * 30'(BUCKETS);
  assign rem_fix = (rem_r >= (BW+1)'(BUCKETS)) ? rem_r - (BW+1)'(BUCKETS) : rem_r;

  assign slot = cmd.alloc_free ? free_head_r : fresh_r;

  always_comb begin
    head_we = 1'b0;
    head_wa = b_r;
    head_wd = slot;
    if (cmd.clr_wr) begin
      head_we = 1'b1;
      head_wa = clr_cnt_r;
      head_wd = NIL;
    end else if (cmd.alloc_fresh || cmd.alloc_free) begin
      head_we = 1'b1;
    end else if (cmd.unlink && prev_r == NIL) begin
      head_we = 1'b1;
      head_wd = nxt_r;
    end
  end

  always_comb begin
    link_we   = 1'b0;
    link_wa_s = slot;
    link_wd   = headv_r;
    if (cmd.alloc_fresh || cmd.alloc_free) begin
      link_we = 1'b1;
    end else if (cmd.rm_link) begin
      link_we   = 1'b1;
      link_wa_s = cur_r;
      link_wd   = free_head_r;
    end else if (cmd.unlink && prev_r != NIL) begin
      link_we   = 1'b1;
      link_wa_s = prev_r;
      link_wd   = nxt_r;
    end
  end

  assign kv_we    = cmd.alloc_fresh || cmd.alloc_free;
  assign val_we   = kv_we || cmd.wr_val_cur;
  assign val_wa_s = cmd.wr_val_cur ? cur_r : slot;
  assign ent_ra   = cmd.rd_free ? free_head_r[IW-1:0] : cur_r[IW-1:0];

  chm_ram #(.WIDTH(SW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(b_r), .rd_data(head_rd)
  );
  chm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .wr_en(kv_we), .wr_addr(slot[IW-1:0]), .wr_data(item_r.key),
    .rd_addr(ent_ra), .rd_data(key_rd)
  );
  chm_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .wr_en(val_we), .wr_addr(val_wa_s[IW-1:0]), .wr_data(item_r.value),
    .rd_addr(ent_ra), .rd_data(val_rd)
  );
  chm_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link (
    .clk(clk), .wr_en(link_we), .wr_addr(link_wa_s[IW-1:0]), .wr_data(link_wd),
    .rd_addr(ent_ra), .rd_data(link_rd)
  );

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    q_r   <= 30'(p1 >> SH);
    rem_r <= (BW+1)'(x - p2);
    if (cmd.load) begin
      item_r  <= in_data;
      prev_r  <= NIL;
      found_r <= 1'b0;
      oldv_r  <= 32'd0;
      full_r  <= 1'b0;
    end
    if (cmd.hash_cap) begin
      b_r <= rem_fix[BW-1:0];
    end
    if (cmd.cur_from_head) begin
      cur_r   <= head_rd;
      headv_r <= head_rd;
    end
    if (cmd.hit) begin
      found_r <= 1'b1;
      oldv_r  <= val_rd;
      nxt_r   <= link_rd;
    end
    if (cmd.advance) begin
      prev_r <= cur_r;
      cur_r  <= link_rd;
    end
    if (cmd.set_full) begin
      full_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_r.found       <= found_r && (item_r.mode != MODE_NONE);
      out_r.old_value   <= (item_r.mode == MODE_NONE) ? 32'd0 : oldv_r;
      out_r.entry_total <= 11'(live_r);
      out_r.pool_full   <= full_r;
    end
  end

  // Pool bookkeeping and the bucket-head clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= NIL;
      fresh_r     <= '0;
      live_r      <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.alloc_fresh) begin
        fresh_r <= fresh_r + 1'b1;
        live_r  <= live_r + 1'b1;
      end
      if (cmd.alloc_free) begin
        free_head_r <= link_rd;
        live_r      <= live_r + 1'b1;
      end
      if (cmd.rm_link) begin
        free_head_r <= cur_r;
        if (live_r != '0) begin
          live_r <= live_r - 1'b1;
        end
      end
    end
  end

  assign stat.cur_nil     = (cur_r == NIL);
  assign stat.key_match   = (key_rd == item_r.key);
  assign stat.free_nil    = (free_head_r == NIL);
  assign stat.fresh_avail = (fresh_r != NIL);
  assign stat.clr_last    = (clr_cnt_r == BW'(BUCKETS - 1));
  assign stat.mode        = item_r.mode;

  assign out_data = out_r;

endmodule
`default_nettype wire

>>> hdl/chm_ctrl.sv
// Controller state machine of the chained hash map: head clearing, hashing,
// chain walk, update sequence and the result handshake. Depends on chm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire chm_pkg::stat_t stat,
  output chm_pkg::cmd_t       cmd
);
  import chm_pkg::*;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_H1     = 4'd2;
  localparam logic [3:0] ST_H2     = 4'd3;
  localparam logic [3:0] ST_H3     = 4'd4;
  localparam logic [3:0] ST_HEAD   = 4'd5;
  localparam logic [3:0] ST_HWAIT  = 4'd6;
  localparam logic [3:0] ST_READ   = 4'd7;
  localparam logic [3:0] ST_CMP    = 4'd8;
  localparam logic [3:0] ST_ACT    = 4'd9;
  localparam logic [3:0] ST_FWAIT  = 4'd10;
  localparam logic [3:0] ST_UNLINK = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_H1;
        end
      end
      ST_H1: state_nxt = ST_H2;
      ST_H2: state_nxt = ST_H3;
      ST_H3: begin
        cmd.hash_cap = 1'b1;
        state_nxt    = ST_HEAD;
      end
      ST_HEAD: state_nxt = ST_HWAIT;
      ST_HWAIT: begin
        cmd.cur_from_head = 1'b1;
        state_nxt         = ST_READ;
      end
      ST_READ: begin
        state_nxt = stat.cur_nil ? ST_ACT : ST_CMP;
      end
      ST_CMP: begin
        if (stat.key_match) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_ACT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_ACT: begin
        state_nxt = ST_DONE;
        case (stat.mode)
          MODE_PUT: begin
            if (!stat.cur_nil) begin
              cmd.wr_val_cur = 1'b1;
            end else if (!stat.free_nil) begin
              cmd.rd_free = 1'b1;
              state_nxt   = ST_FWAIT;
            end else if (stat.fresh_avail) begin
              cmd.alloc_fresh = 1'b1;
            end else begin
              cmd.set_full = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (!stat.cur_nil) begin
              cmd.rm_link = 1'b1;
              state_nxt   = ST_UNLINK;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_FWAIT: begin
        cmd.alloc_free = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hdl/chained_hash_map.sv
// Top level of the chained hash map: controller and datapath.
// Depends on chm_pkg, chm_ctrl, chm_dp (and chm_ram through chm_dp).
//
// Usage: a key-value map with separate chaining over a pool of CAPACITY entries
// spread over BUCKETS chains. Each input transaction on in_data is a put, get or
// remove of one 32-bit key; every input transaction yields exactly one output
// transaction on out_data with the found flag, the previous value, the entry
// count after the operation and the pool-full flag.
// Both channels use valid/stall: a transaction moves on a rising edge where valid
// is high and stall is low.
// Sequence: the key is hashed in states H1, H2 and H3 and the bucket head is
// read in HEAD and HWAIT. Each chain node visited takes an entry read (READ),
// then a compare (CMP); a chain end (NIL) goes from READ straight to ACT. A
// remove of a present key adds UNLINK and a put that reuses a released entry
// adds FWAIT before the result register loads in DONE. in_stall drops when the
// result loads, so one operation is in flight at a time.
// Reset: after rst_n the block clears all BUCKETS chain heads, one per cycle,
// and keeps in_stall high for those BUCKETS cycles.
// The result sits in an output register; the next input transaction is accepted
// while it waits, and a finished operation holds until out_stall drops.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_map #(
  parameter int BUCKETS  = chm_pkg::BUCKETS_DEF,
  parameter int CAPACITY = chm_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire chm_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output chm_pkg::out_t      out_data
);
  import chm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  chm_dp #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
